>>> rtl/cmis_pkg.sv
`default_nettype none
package cmis_pkg;

  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS    = 1024;
  localparam int FRAC_BITS   = 16;

  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int ROW_W   = $clog2(MAX_ROWS + 1);
  localparam int SAMP_W  = FRAC_BITS + 1;
  localparam int SUM_W   = SAMP_W + ROW_W - 1;
  localparam int SQ_W    = 2 * SAMP_W + ROW_W - 1;
  // Root width first; the radicand is kept at an even width of bit pairs
  localparam int R_W     = (SQ_W + ROW_W + 1) / 2;
  localparam int D_W     = 2 * R_W;
  localparam int NUM_W   = ROW_W + FRAC_BITS + 16;
  localparam int CCNT_W  = 7;
  localparam int LBL_W   = 12;
  localparam int OLBL_W  = 13;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_SAT     = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_DROPPED = 2'd3;

  localparam logic [0:0] REG_COLUMN_COUNT = 1'b0;
  localparam logic [0:0] REG_FIRST_LABEL  = 1'b1;

  // Controller commands to the datapath
  typedef struct packed {
    logic clear;
    logic sample_rd;
    logic sample_wr;
    logic fin_rd;
    logic mul_a;
    logic mul_b;
    logic sqrt_start;
    logic div_start;
    logic emit;
    logic emit_err;
    logic [COL_W-1:0] col;
    logic last;
  } cmis_cmd_t;

  typedef struct packed {
    logic sqrt_done;
    logic div_done;
  } cmis_stat_t;

endpackage
`default_nettype wire

>>> rtl/cmis_datapath.sv
`default_nettype none
module cmis_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire cmis_pkg::cmis_cmd_t           cmd,
  input  wire logic [cmis_pkg::SAMP_W-1:0]   in_sample,
  input  wire logic [cmis_pkg::COL_W-1:0]    sample_col,
  input  wire logic                          acc_en,
  input  wire logic [cmis_pkg::ROW_W-1:0]    row_total,
  input  wire logic                          rows_dropped,
  input  wire logic [cmis_pkg::LBL_W-1:0]    first_label,
  output cmis_pkg::cmis_stat_t               stat,
  output logic                               out_valid,
  output logic [cmis_pkg::OLBL_W-1:0]        out_label,
  output logic [cmis_pkg::SAMP_W-1:0]        out_mean,
  output logic [31:0]                        out_inv_spread,
  output logic [1:0]                         out_status,
  output logic                               out_last
);
  import cmis_pkg::*;

  localparam logic [SAMP_W-1:0] ONE = SAMP_W'(1) << FRAC_BITS;
  localparam int QB_W = NUM_W;
  localparam int SQ_STEPS = R_W;
  localparam int SQ_CW = $clog2(SQ_STEPS + 1);
  localparam int DV_CW = $clog2(QB_W + 1);

  logic [SUM_W-1:0] sum_mem [MAX_COLUMNS];
  logic [SQ_W-1:0]  sq_mem  [MAX_COLUMNS];
  logic [SUM_W-1:0] sum_rd_r;
  logic [SQ_W-1:0]  sq_rd_r;
  logic [SAMP_W-1:0] x_r;
  logic [2*SAMP_W-1:0] xx_r;
  logic [COL_W-1:0] wcol_r;
  logic acc_r;

  logic [D_W-1:0] nsq_r, ss_r, d_r;
  logic [SAMP_W-1:0] mean_r;
  logic [D_W-1:0] sq_rem_r;
  logic [R_W-1:0] root_r;
  logic [SQ_CW-1:0] sq_cnt_r;
  logic sq_busy_r;
  logic [NUM_W-1:0] num_r;
  logic [QB_W-1:0] quo_r;
  logic [R_W:0] drem_r;
  logic [DV_CW-1:0] dv_cnt_r;
  logic dv_busy_r;
  logic [SUM_W-1:0] mrem_r;
  logic [SAMP_W-1:0] mquo_r;

  logic [SAMP_W-1:0] x_sat;
  assign x_sat = (in_sample > ONE) ? ONE : in_sample;

  // Sample: read column, square, then write back
  always_ff @(posedge clk) begin
    if (cmd.sample_rd || cmd.fin_rd) begin
      sum_rd_r <= sum_mem[cmd.sample_rd ? sample_col : cmd.col];
      sq_rd_r  <= sq_mem[cmd.sample_rd ? sample_col : cmd.col];
    end
    if (cmd.sample_rd) begin
      x_r    <= x_sat;
      xx_r   <= x_sat * x_sat;
      wcol_r <= sample_col;
      acc_r  <= acc_en;
    end
    if (cmd.clear) begin
      sum_mem[cmd.col] <= '0;
      sq_mem[cmd.col]  <= '0;
    end else if (cmd.sample_wr && acc_r) begin
      sum_mem[wcol_r] <= sum_rd_r + SUM_W'(x_r);
      sq_mem[wcol_r]  <= sq_rd_r + SQ_W'(xx_r);
    end
  end

  // Variance numerator: both products in the same cycle, difference in the next
  always_ff @(posedge clk) begin
    if (cmd.mul_a) begin
      nsq_r <= D_W'(row_total) * D_W'(sq_rd_r);
      ss_r  <= D_W'(sum_rd_r) * D_W'(sum_rd_r);
    end
  end

  // Root: one result bit per cycle; mean divide rides along
  logic [R_W+1:0] trial;
  logic [D_W-1:0] rem_sh;
  assign rem_sh = {sq_rem_r[D_W-3:0], d_r[D_W-1 -: 2]};
  assign trial  = {root_r, 2'b01};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_busy_r <= 1'b0;
    end else if (cmd.mul_b) begin
      d_r <= nsq_r - ss_r;
    end else if (cmd.sqrt_start) begin
      sq_busy_r <= 1'b1;
      sq_cnt_r  <= SQ_CW'(SQ_STEPS);
      sq_rem_r  <= '0;
      root_r    <= '0;
    end else if (sq_busy_r) begin
      d_r <= d_r << 2;
      if (rem_sh >= D_W'(trial)) begin
        sq_rem_r <= rem_sh - D_W'(trial);
        root_r   <= {root_r[R_W-2:0], 1'b1};
      end else begin
        sq_rem_r <= rem_sh;
        root_r   <= {root_r[R_W-2:0], 1'b0};
      end
      sq_cnt_r <= sq_cnt_r - 1'b1;
      if (sq_cnt_r == SQ_CW'(1)) sq_busy_r <= 1'b0;
    end
  end

  // Mean: restoring divide of sum by row count, one bit per cycle
  logic [SUM_W:0] mtry;
  logic [4:0] mcnt_r;
  logic mbusy_r;
  logic [SUM_W-1:0] msum_r;
  assign mtry = {mrem_r, msum_r[SUM_W-1]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
    end else if (cmd.sqrt_start) begin
      mbusy_r <= 1'b1;
      mcnt_r  <= 5'(SUM_W);
      msum_r  <= sum_rd_r;
      mrem_r  <= '0;
      mquo_r  <= '0;
    end else if (mbusy_r) begin
      msum_r <= msum_r << 1;
      if (mtry >= (SUM_W+1)'(row_total)) begin
        mrem_r <= SUM_W'(mtry - (SUM_W+1)'(row_total));
        mquo_r <= {mquo_r[SAMP_W-2:0], 1'b1};
      end else begin
        mrem_r <= SUM_W'(mtry);
        mquo_r <= {mquo_r[SAMP_W-2:0], 1'b0};
      end
      mcnt_r <= mcnt_r - 1'b1;
      if (mcnt_r == 5'd1) mbusy_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.div_start) mean_r <= mquo_r;
  end
  assign stat.sqrt_done = !sq_busy_r && !mbusy_r;

  // Reciprocal: restoring divide num / root, one bit per cycle
  logic [R_W+1:0] dtry;
  assign dtry = {drem_r, num_r[NUM_W-1]};
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      dv_busy_r <= (root_r != '0);
      dv_cnt_r  <= DV_CW'(QB_W);
      drem_r    <= '0;
      quo_r     <= '0;
      num_r     <= NUM_W'(row_total) << (FRAC_BITS + 16);
    end else if (dv_busy_r) begin
      num_r <= num_r << 1;
      if (dtry >= (R_W+2)'(root_r)) begin
        drem_r <= (R_W+1)'(dtry - (R_W+2)'(root_r));
        quo_r  <= {quo_r[QB_W-2:0], 1'b1};
      end else begin
        drem_r <= (R_W+1)'(dtry);
        quo_r  <= {quo_r[QB_W-2:0], 1'b0};
      end
      dv_cnt_r <= dv_cnt_r - 1'b1;
      if (dv_cnt_r == DV_CW'(1)) dv_busy_r <= 1'b0;
    end
  end
  assign stat.div_done = !dv_busy_r;

  // Output register
  logic sat;
  assign sat = (root_r == '0) || (quo_r[QB_W-1:32] != '0);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit || cmd.emit_err;
    end
    if (cmd.emit_err) begin
      out_label      <= OLBL_W'(first_label);
      out_mean       <= '0;
      out_inv_spread <= '0;
      out_status     <= ST_EMPTY;
      out_last       <= 1'b1;
    end else if (cmd.emit) begin
      out_label      <= OLBL_W'(first_label) + OLBL_W'(cmd.col);
      out_mean       <= mean_r;
      out_inv_spread <= sat ? 32'hFFFF_FFFF : quo_r[31:0];
      out_status     <= rows_dropped ? ST_DROPPED : (sat ? ST_SAT : ST_OK);
      out_last       <= cmd.last;
    end
  end
endmodule
`default_nettype wire

>>> rtl/cmis_ctrl.sv
`default_nettype none
module cmis_ctrl (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          in_kind,
  input  wire logic [cmis_pkg::CCNT_W-1:0]   column_count,
  input  wire cmis_pkg::cmis_stat_t          stat,
  output cmis_pkg::cmis_cmd_t                cmd,
  output logic                               busy,
  output logic [cmis_pkg::COL_W-1:0]         sample_col,
  output logic                               acc_en,
  output logic [cmis_pkg::ROW_W-1:0]         row_total,
  output logic                               rows_dropped
);
  import cmis_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_WR    = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_MULA  = 4'd3;
  localparam logic [3:0] S_MULB  = 4'd4;
  localparam logic [3:0] S_SQ0   = 4'd5;
  localparam logic [3:0] S_SQ    = 4'd6;
  localparam logic [3:0] S_DV    = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;
  localparam logic [3:0] S_CLR   = 4'd9;

  logic [3:0] state_r, state_nxt;
  logic [COL_W-1:0] col_pos_r, col_r, col_nxt;
  logic [ROW_W-1:0] row_r;
  logic drop_r;
  logic [COL_W:0] ncols;
  logic accept;

  assign ncols = (column_count == '0) ? (COL_W+1)'(1) :
                 (column_count > CCNT_W'(MAX_COLUMNS)) ? (COL_W+1)'(MAX_COLUMNS) :
                 (COL_W+1)'(column_count);
  assign busy = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign sample_col = col_pos_r;
  assign acc_en = (row_r < ROW_W'(MAX_ROWS));
  assign row_total = row_r;
  assign rows_dropped = drop_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    col_nxt   = col_r;
    cmd       = '0;
    cmd.col   = col_r;
    cmd.last  = ((COL_W+1)'(col_r) + 1'b1 == ncols);
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_kind) begin
            cmd.sample_rd = 1'b1;
            state_nxt = S_WR;
          end else if (row_r == '0 || col_pos_r != '0) begin
            cmd.emit_err = 1'b1;
            col_nxt = '0;
            state_nxt = S_CLR;
          end else begin
            col_nxt = '0;
            state_nxt = S_RD;
          end
        end
      end
      S_WR: begin
        cmd.sample_wr = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RD:   begin cmd.fin_rd = 1'b1; state_nxt = S_MULA; end
      S_MULA: begin cmd.mul_a = 1'b1; state_nxt = S_MULB; end
      S_MULB: begin cmd.mul_b = 1'b1; state_nxt = S_SQ0; end
      S_SQ0:  begin cmd.sqrt_start = 1'b1; state_nxt = S_SQ; end
      S_SQ: begin
        if (stat.sqrt_done) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DV;
        end
      end
      S_DV: if (stat.div_done) state_nxt = S_EMIT;
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (cmd.last) begin
          col_nxt = '0;
          state_nxt = S_CLR;
        end else begin
          col_nxt = col_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_CLR: begin
        cmd.clear = 1'b1;
        col_nxt = col_r + 1'b1;
        if (col_r == COL_W'(MAX_COLUMNS - 1)) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state, column walk, row count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      col_r     <= '0;
      col_pos_r <= '0;
      row_r     <= '0;
      drop_r    <= 1'b0;
    end else begin
      state_r <= (state_r == S_IDLE && accept && !in_kind) ? S_WR : state_nxt;
      col_r   <= col_nxt;
      if (cmd.clear && state_nxt == S_IDLE) begin
        col_pos_r <= '0;
        row_r     <= '0;
        drop_r    <= 1'b0;
      end else if (accept && !in_kind) begin
        if (!acc_en) drop_r <= 1'b1;
        if ((COL_W+1)'(col_pos_r) + 1'b1 >= ncols) begin
          col_pos_r <= '0;
          if (acc_en) row_r <= row_r + 1'b1;
        end else begin
          col_pos_r <= col_pos_r + 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/column_mean_inverse_sd.sv
`default_nettype none
// Per-column mean and reciprocal population standard deviation.
// Input: raise start with in_kind/in_sample; the item is taken at the edge
// where busy is low. in_kind 0 adds one sample to the current column by a
// read-modify-write of the column store; busy stays high for the write-back.
// in_kind 1 finishes the set. Per column: read the sums, form
// N*sumsq-sum^2, start the root, take the root one bit per cycle over 28
// steps with the mean divide alongside, divide N*2^32 by the root one bit
// per cycle over 43 steps (skipped when the root is zero) and emit.
// Each result is held for one cycle with out_valid high, in the cycle after
// its emit; out_last marks the final column. The receiver cannot stall.
// A finish with no rows or a part row gives one status-2 result in the cycle
// after the item is taken.
// After every finish a clearing pass over all 64 columns wipes the column
// store while busy stays high, so no item is taken until the pass ends.
// Reset clears counters and control and runs the same clearing pass, with
// busy high, before the first item is taken.
// Registers on the APB-style cfg_ port: 0 column_count, 4 first_label.
module column_mean_inverse_sd (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_kind,
  input  wire logic [16:0] in_sample,
  output logic             out_valid,
  output logic [12:0]      out_label,
  output logic [16:0]      out_mean,
  output logic [31:0]      out_inv_spread,
  output logic [1:0]       out_status,
  output logic             out_last,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import cmis_pkg::*;

  logic [CCNT_W-1:0] ccnt_r;
  logic [LBL_W-1:0]  lbl_r;
  cmis_cmd_t cmd_dp, cmd_c;
  cmis_stat_t stat;
  logic [COL_W-1:0] scol;
  logic acc_en, drop, busy_c;
  logic [ROW_W-1:0] rows;
  logic init_r;
  logic [COL_W-1:0] icol_r;

  assign cfg_pready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ccnt_r <= CCNT_W'(1);
      lbl_r  <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr[2])
        REG_COLUMN_COUNT: ccnt_r <= cfg_pwdata[CCNT_W-1:0];
        REG_FIRST_LABEL:  lbl_r  <= cfg_pwdata[LBL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg_prdata = '0;
    unique case (cfg_paddr[2])
      REG_COLUMN_COUNT: cfg_prdata = 32'(ccnt_r);
      REG_FIRST_LABEL:  cfg_prdata = 32'(lbl_r);
      default: ;
    endcase
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_r <= 1'b1;
      icol_r <= '0;
    end else if (init_r) begin
      icol_r <= icol_r + 1'b1;
      if (icol_r == COL_W'(MAX_COLUMNS - 1)) init_r <= 1'b0;
    end
  end

  always_comb begin
    cmd_dp = cmd_c;
    if (init_r) begin
      cmd_dp = '0;
      cmd_dp.clear = 1'b1;
      cmd_dp.col = icol_r;
    end
  end
  assign busy = busy_c || init_r;

  cmis_ctrl u_ctrl (
    .clk, .rst_n,
    .start(start && !init_r),
    .in_kind,
    .column_count(ccnt_r),
    .stat,
    .cmd(cmd_c),
    .busy(busy_c),
    .sample_col(scol),
    .acc_en,
    .row_total(rows),
    .rows_dropped(drop)
  );

  cmis_datapath u_dp (
    .clk, .rst_n,
    .cmd(cmd_dp),
    .in_sample,
    .sample_col(scol),
    .acc_en,
    .row_total(rows),
    .rows_dropped(drop),
    .first_label(lbl_r),
    .stat,
    .out_valid,
    .out_label,
    .out_mean,
    .out_inv_spread,
    .out_status,
    .out_last
  );
endmodule
`default_nettype wire
